@@ sv/bma_pkg.sv @@
// Shared widths, scaling constants and inter-stage beat types of the battery level filter.
`timescale 1ns / 1ps
`default_nettype none

package bma_pkg;

    localparam int unsigned SAMPLE_W  = 12;
    localparam int unsigned SUM_W     = 16;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned BARS_W    = 2;
    localparam int unsigned MAX_WINDOW = 16;

    // The average is taken as sum * ceil(2^AVG_SHIFT / WINDOW) >> AVG_SHIFT.
    // With a 16-bit sum and a window of at most sixteen this is exact.
    localparam int unsigned AVG_SHIFT  = 21;
    localparam int unsigned AVG_MULT_W = AVG_SHIFT + 1;

    // The percentage is taken as (avg * 100) * ceil(2^31 / 4095) >> 31, exact for avg < 4096.
    localparam int unsigned SCALED_W   = 19;
    localparam int unsigned PCT_SHIFT  = 31;
    localparam int unsigned PCT_MULT_W = 20;
    localparam logic [PCT_MULT_W-1:0] PCT_MULT  = 20'd524417;
    localparam logic [SCALED_W-1:0]   PCT_SCALE = 19'd100;

    localparam logic [PCT_W-1:0]  PCT_MAX     = 7'd100;
    localparam logic [PCT_W-1:0]  PCT_ZERO    = 7'd0;
    localparam logic [PCT_W-1:0]  ONE_BAR_MAX = 7'd33;
    localparam logic [PCT_W-1:0]  TWO_BAR_MAX = 7'd66;

    localparam logic [BARS_W-1:0] BARS_NONE  = 2'd0;
    localparam logic [BARS_W-1:0] BARS_ONE   = 2'd1;
    localparam logic [BARS_W-1:0] BARS_TWO   = 2'd2;
    localparam logic [BARS_W-1:0] BARS_THREE = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             priming;
    } window_beat_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] avg;
        logic                priming;
    } avg_beat_t;

endpackage

`default_nettype wire

@@ sv/bma_if.sv @@
// Valid/ready channel interfaces for ADC sample beats and battery level beats.
`timescale 1ns / 1ps
`default_nettype none

interface bma_in_if;
    import bma_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface bma_out_if;
    import bma_pkg::*;

    logic              valid;
    logic              ready;
    logic [PCT_W-1:0]  level_percent;
    logic [BARS_W-1:0] bar_count;
    logic              level_changed;
    logic              priming;

    modport source (output valid, output level_percent, output bar_count,
                    output level_changed, output priming, input ready);
    modport sink (input valid, input level_percent, input bar_count,
                  input level_changed, input priming, output ready);
endinterface

`default_nettype wire

@@ sv/bma_window.sv @@
// Sample input register, ring of recent samples and running window sum.
`timescale 1ns / 1ps
`default_nettype none

module bma_window #(
    parameter int unsigned WINDOW = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bma_in_if.sink                samples,
    output logic                  sum_valid,
    input  logic                  sum_ready,
    output bma_pkg::window_beat_t sum_beat
);
    import bma_pkg::*;

    localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] store_reg [WINDOW];
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                full_reg;
    logic                sum_valid_reg;
    window_beat_t        beat_reg;
    logic                hold_ok;
    logic                in_ready;
    logic                fire;
    logic                wrap;

    assign hold_ok       = !sum_valid_reg || sum_ready;
    assign fire          = in_valid_reg && hold_ok;
    assign in_ready      = !in_valid_reg || hold_ok;
    assign samples.ready = in_ready;

    assign wrap      = (slot_reg == LAST_SLOT);
    assign slot_next = wrap ? '0 : slot_reg + 1'b1;
    assign sum_next  = sum_reg - SUM_W'(store_reg[slot_reg]) + SUM_W'(sample_reg);

    assign sum_valid = sum_valid_reg;
    assign sum_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= samples.valid;
            end
            if (hold_ok)
            begin
                sum_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && in_ready)
        begin
            sample_reg <= samples.sample;
        end
        if (fire)
        begin
            beat_reg.sum     <= sum_next;
            beat_reg.priming <= !full_reg;
        end
    end

    // The priming phase ends when the write slot first wraps back to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                store_reg[i] <= '0;
            end
            slot_reg <= '0;
            sum_reg  <= '0;
            full_reg <= 1'b0;
        end
        else if (fire)
        begin
            store_reg[slot_reg] <= sample_reg;
            slot_reg            <= slot_next;
            sum_reg             <= sum_next;
            if (wrap)
            begin
                full_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/bma_average.sv @@
// Window average stage: reciprocal multiply of the window sum, registered.
`timescale 1ns / 1ps
`default_nettype none

module bma_average #(
    parameter int unsigned WINDOW = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sum_valid,
    output logic                  sum_ready,
    input  bma_pkg::window_beat_t sum_beat,
    output logic                  avg_valid,
    input  logic                  avg_ready,
    output bma_pkg::avg_beat_t    avg_beat
);
    import bma_pkg::*;

    localparam logic [AVG_MULT_W-1:0] AVG_MULT =
        AVG_MULT_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam int unsigned PROD_W = SUM_W + AVG_MULT_W;

    logic              avg_valid_reg;
    avg_beat_t         beat_reg;
    logic              hold_ok;
    logic [PROD_W-1:0] product;

    assign hold_ok   = !avg_valid_reg || avg_ready;
    assign sum_ready = hold_ok;
    assign product   = PROD_W'(sum_beat.sum) * PROD_W'(AVG_MULT);

    assign avg_valid = avg_valid_reg;
    assign avg_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_valid_reg <= 1'b0;
        end
        else if (hold_ok)
        begin
            avg_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid && hold_ok)
        begin
            beat_reg.avg     <= product[AVG_SHIFT +: SAMPLE_W];
            beat_reg.priming <= sum_beat.priming;
        end
    end

endmodule

`default_nettype wire

@@ sv/bma_level.sv @@
// Percentage and bar mapping, held level compare and the result register.
`timescale 1ns / 1ps
`default_nettype none

module bma_level (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               avg_valid,
    output logic               avg_ready,
    input  bma_pkg::avg_beat_t avg_beat,
    bma_out_if.source          levels
);
    import bma_pkg::*;

    localparam int unsigned PCT_PROD_W = SCALED_W + PCT_MULT_W;

    logic                  out_valid_reg;
    logic [PCT_W-1:0]      out_pct_reg;
    logic [BARS_W-1:0]     out_bars_reg;
    logic                  out_changed_reg;
    logic                  out_priming_reg;
    logic [PCT_W-1:0]      held_pct_reg;
    logic [PCT_W-1:0]      held_pct_next;
    logic [BARS_W-1:0]     held_bars_reg;
    logic [BARS_W-1:0]     held_bars_next;
    logic                  hold_ok;
    logic                  take;
    logic [SCALED_W-1:0]   scaled;
    logic [PCT_PROD_W-1:0] pct_prod;
    logic [PCT_W-1:0]      pct_raw;
    logic [PCT_W-1:0]      pct;
    logic [BARS_W-1:0]     bars;
    logic                  changed;

    assign hold_ok   = !out_valid_reg || levels.ready;
    assign avg_ready = hold_ok;
    assign take      = avg_valid && hold_ok;

    assign scaled   = SCALED_W'(avg_beat.avg) * PCT_SCALE;
    assign pct_prod = PCT_PROD_W'(scaled) * PCT_PROD_W'(PCT_MULT);
    assign pct_raw  = pct_prod[PCT_SHIFT +: PCT_W];
    assign pct      = (pct_raw > PCT_MAX) ? PCT_MAX : pct_raw;

    always_comb
    begin
        if (pct == PCT_ZERO)
        begin
            bars = BARS_NONE;
        end
        else if (pct <= ONE_BAR_MAX)
        begin
            bars = BARS_ONE;
        end
        else if (pct <= TWO_BAR_MAX)
        begin
            bars = BARS_TWO;
        end
        else
        begin
            bars = BARS_THREE;
        end
    end

    // Priming beats report the held level unchanged.
    assign changed = !avg_beat.priming && ((pct != held_pct_reg) || (bars != held_bars_reg));
    assign held_pct_next  = changed ? pct : held_pct_reg;
    assign held_bars_next = changed ? bars : held_bars_reg;

    assign levels.valid         = out_valid_reg;
    assign levels.level_percent = out_pct_reg;
    assign levels.bar_count     = out_bars_reg;
    assign levels.level_changed = out_changed_reg;
    assign levels.priming       = out_priming_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_pct_reg  <= PCT_MAX;
            held_bars_reg <= BARS_THREE;
        end
        else
        begin
            if (hold_ok)
            begin
                out_valid_reg <= avg_valid;
            end
            if (take)
            begin
                held_pct_reg  <= held_pct_next;
                held_bars_reg <= held_bars_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_pct_reg     <= held_pct_next;
            out_bars_reg    <= held_bars_next;
            out_changed_reg <= changed;
            out_priming_reg <= avg_beat.priming;
        end
    end

endmodule

`default_nettype wire

@@ sv/battery_level_moving_average_unit.sv @@
// Top level of the battery level moving-average filter.
//
//   channel   modport  beat payload
//   samples   sink     sample (12-bit ADC reading)
//   levels    source   level_percent, bar_count, level_changed, priming
//
// One beat can be accepted every cycle unless a stall on levels backs up; each result
// passes the sample input register and the window, average and level registers.
// The ring and window sum are updated together as a beat leaves the input register,
// so back-to-back samples never wait on one another. Reset clears the ring, the sum
// and the priming state and holds the level at 100 percent and three bars. A stall on
// levels holds every stage; samples.ready drops only once all stages hold a beat.
`timescale 1ns / 1ps
`default_nettype none

module battery_level_moving_average_unit #(
    parameter int unsigned WINDOW = 10
) (
    input  logic      clk,
    input  logic      rst_n,
    bma_in_if.sink    samples,
    bma_out_if.source levels
);
    import bma_pkg::*;

    logic         sum_valid;
    logic         sum_ready;
    window_beat_t sum_beat;
    logic         avg_valid;
    logic         avg_ready;
    avg_beat_t    avg_beat;

    bma_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum_beat  (sum_beat)
    );

    bma_average #(
        .WINDOW (WINDOW)
    ) u_average (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum_beat  (sum_beat),
        .avg_valid (avg_valid),
        .avg_ready (avg_ready),
        .avg_beat  (avg_beat)
    );

    bma_level u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .avg_valid (avg_valid),
        .avg_ready (avg_ready),
        .avg_beat  (avg_beat),
        .levels    (levels)
    );

endmodule

`default_nettype wire

@@ dv/battery_level_moving_average_unit_tb.sv @@
// Self-checking testbench for the battery level moving-average filter with random flow control.
`timescale 1ns / 1ps

module battery_level_moving_average_unit_tb;
    import bma_pkg::*;

    localparam int unsigned WINDOW_LEN = 10;
    localparam int unsigned FULL_SCALE = 4095;
    localparam int unsigned RANDOM_SAMPLES = 1500;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [PCT_W-1:0]  level_percent;
        logic [BARS_W-1:0] bar_count;
        logic              level_changed;
        logic              priming;
    } level_beat_t;

    class level_scoreboard;
        logic [SAMPLE_W-1:0] ring [MAX_WINDOW];
        logic [SUM_W-1:0]    ring_sum;
        int unsigned         slot;
        bit                  ring_full;
        logic [PCT_W-1:0]    held_percent;
        logic [BARS_W-1:0]   held_bars;
        level_beat_t         expected_levels[$];
        int unsigned         errors;

        function new();
            foreach (ring[i])
            begin
                ring[i] = '0;
            end
            ring_sum = '0;
            slot = 0;
            ring_full = 0;
            held_percent = PCT_MAX;
            held_bars = BARS_THREE;
            errors = 0;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            int unsigned       avg;
            int unsigned       pct;
            logic [BARS_W-1:0] bars;
            level_beat_t       beat;
            beat.priming = !ring_full;
            beat.level_changed = 1'b0;
            ring_sum = ring_sum - ring[slot] + s;
            ring[slot] = s;
            slot = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;
            if (!ring_full)
            begin
                if (slot == 0)
                begin
                    ring_full = 1;
                end
            end
            else
            begin
                avg = ring_sum / WINDOW_LEN;
                pct = avg * 100 / FULL_SCALE;
                if (pct > PCT_MAX)
                begin
                    pct = PCT_MAX;
                end
                if (pct == PCT_ZERO)
                begin
                    bars = BARS_NONE;
                end
                else if (pct <= ONE_BAR_MAX)
                begin
                    bars = BARS_ONE;
                end
                else if (pct <= TWO_BAR_MAX)
                begin
                    bars = BARS_TWO;
                end
                else
                begin
                    bars = BARS_THREE;
                end
                if (pct[PCT_W-1:0] != held_percent || bars != held_bars)
                begin
                    held_percent = pct[PCT_W-1:0];
                    held_bars = bars;
                    beat.level_changed = 1'b1;
                end
            end
            beat.level_percent = held_percent;
            beat.bar_count = held_bars;
            expected_levels.push_back(beat);
        endfunction

        function void check_level(level_beat_t got);
            level_beat_t want;
            if (expected_levels.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                begin
                    $display("ERROR: unexpected level beat: pct=%0d bars=%0d chg=%0b prim=%0b",
                             got.level_percent, got.bar_count, got.level_changed,
                             got.priming);
                end
                errors++;
                return;
            end
            want = expected_levels.pop_front();
            if (got !== want)
            begin
                if (errors < MAX_REPORTS)
                begin
                    $display("ERROR: level beat mismatch: expected pct=%0d bars=%0d chg=%0b prim=%0b",
                             want.level_percent, want.bar_count, want.level_changed,
                             want.priming);
                    $display("       got pct=%0d bars=%0d chg=%0b prim=%0b",
                             got.level_percent, got.bar_count, got.level_changed,
                             got.priming);
                end
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_levels.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bma_in_if  samples();
    bma_out_if levels();

    battery_level_moving_average_unit #(
        .WINDOW(WINDOW_LEN)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples),
        .levels(levels)
    );

    level_scoreboard sb = new();
    int unsigned     idle_cycles = 0;
    int unsigned     burst_left = 0;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (samples.valid && samples.ready)
            begin
                sb.note_sample(samples.sample);
            end
            if (levels.valid && levels.ready)
            begin
                sb.check_level({levels.level_percent, levels.bar_count,
                                levels.level_changed, levels.priming});
            end
            if ((samples.valid && samples.ready) || (levels.valid && levels.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("battery_level_moving_average_unit_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                samples.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        samples.valid <= 1'b1;
        samples.sample <= value;
        do
        begin
            @(posedge clk);
        end
        while (!samples.ready);
        @(negedge clk);
    endtask

    task automatic send_level_run(input int unsigned pct, input int unsigned run_len);
        int base;
        int value;
        base = (pct * FULL_SCALE + 99) / 100;
        repeat (run_len)
        begin
            value = base + $urandom_range(0, 4) - 2;
            if (value < 0)
            begin
                value = 0;
            end
            if (value > int'(FULL_SCALE))
            begin
                value = FULL_SCALE;
            end
            send_sample(value[SAMPLE_W-1:0]);
        end
    endtask

    initial
    begin
        int unsigned mode;
        int unsigned mode_left;
        levels.ready = 1'b0;
        mode = 0;
        mode_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: levels.ready <= 1'b1;
                1: levels.ready <= ($urandom_range(0, 2) != 0);
                default: levels.ready <= (mode_left % 8 >= 3);
            endcase
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned run_len;
        samples.valid = 1'b0;
        samples.sample = '0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The window fills with alternating full-scale and zero samples, then the level
        // is driven from half scale down to empty and back up.
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            send_sample((i % 2 == 0) ? SAMPLE_W'(FULL_SCALE) : '0);
        end
        send_sample(SAMPLE_W'(FULL_SCALE));
        repeat (WINDOW_LEN) send_sample('0);
        repeat (4) send_sample(SAMPLE_W'(FULL_SCALE));

        sent = 0;
        while (sent < RANDOM_SAMPLES)
        begin
            run_len = $urandom_range(WINDOW_LEN, 4 * WINDOW_LEN);
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    repeat (run_len) send_sample(SAMPLE_W'($urandom_range(0, FULL_SCALE)));
                end
                3:
                begin
                    send_level_run($urandom_range(0, 1) * 100, run_len);
                end
                4:
                begin
                    send_level_run(33 + $urandom_range(0, 1), run_len);
                end
                5:
                begin
                    send_level_run(66 + $urandom_range(0, 1), run_len);
                end
                default:
                begin
                    send_level_run($urandom_range(0, 100), run_len);
                end
            endcase
            sent += run_len;
        end
        samples.valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("battery_level_moving_average_unit_tb OK");
        end
        else
        begin
            $display("battery_level_moving_average_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/bma_pkg.sv
sv/bma_if.sv
sv/bma_window.sv
sv/bma_average.sv
sv/bma_level.sv
sv/battery_level_moving_average_unit.sv
dv/battery_level_moving_average_unit_tb.sv
